/* sv/glcm_pkg.sv */
package glcm_pkg;

   localparam int GRAY_LEVELS_DEF = 256;
   localparam int COUNT_BITS_DEF  = 16;

   localparam int LEVEL_W = 8;
   localparam int BIN_W   = 9;
   localparam int OP_W    = 3;
   localparam int VALUE_W = 16;
   localparam int CSR_AW  = 3;

   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD     = 3'd1;
   localparam logic [OP_W-1:0] OP_RD_CELL = 3'd2;
   localparam logic [OP_W-1:0] OP_RD_SUM  = 3'd3;
   localparam logic [OP_W-1:0] OP_RD_DIFF = 3'd4;
   localparam logic [OP_W-1:0] OP_RD_X    = 3'd5;
   localparam logic [OP_W-1:0] OP_RD_Y    = 3'd6;
   localparam logic [OP_W-1:0] OP_NOP     = 3'd7;

   localparam logic CSR_IDX_SYMMETRIC = 1'b0;

   // command passed from the front end to the execution side
   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [LEVEL_W-1:0] ref_level;
      logic [LEVEL_W-1:0] nbr_level;
      logic [BIN_W-1:0]   bin_index;
      logic               sym;
   } cmd_type;

endpackage

/* sv/glcm_front.sv */
module glcm_front
   import glcm_pkg::*;
#(
   parameter int GRAY_LEVELS = GRAY_LEVELS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OP_W-1:0]     req_op,
   input  logic [LEVEL_W-1:0]  req_ref_level,
   input  logic [LEVEL_W-1:0]  req_nbr_level,
   input  logic [BIN_W-1:0]    req_bin_index,
   input  logic                sym_mode,
   output logic                q_valid,
   output cmd_type             q_cmd,
   input  logic                q_pop
);

   localparam int Q_DEPTH = 2;
   localparam int QP_W    = $clog2(Q_DEPTH);
   localparam int SUM_BINS = 2 * GRAY_LEVELS - 1;

   cmd_type             q_ff [Q_DEPTH];
   logic [QP_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QP_W:0]       count_ff, count_in;
   logic                push;
   logic                ref_ok, nbr_ok;
   cmd_type             cls;

   assign ref_ok = 32'(req_ref_level) < 32'(GRAY_LEVELS);
   assign nbr_ok = 32'(req_nbr_level) < 32'(GRAY_LEVELS);

   // out-of-range operands turn into a no-op that still answers
   always_comb begin
      cls.op        = req_op;
      cls.ref_level = req_ref_level;
      cls.nbr_level = req_nbr_level;
      cls.bin_index = req_bin_index;
      cls.sym       = sym_mode;
      case (req_op)
         OP_CLEAR: cls.op = OP_CLEAR;
         OP_ADD, OP_RD_CELL: begin
            if (!(ref_ok && nbr_ok)) cls.op = OP_NOP;
         end
         OP_RD_SUM: begin
            if (!(32'(req_bin_index) < 32'(SUM_BINS))) cls.op = OP_NOP;
         end
         OP_RD_DIFF: begin
            if (!(32'(req_bin_index) < 32'(GRAY_LEVELS))) cls.op = OP_NOP;
         end
         OP_RD_X: begin
            if (!ref_ok) cls.op = OP_NOP;
         end
         OP_RD_Y: begin
            if (!nbr_ok) cls.op = OP_NOP;
         end
         default: cls.op = OP_NOP;
      endcase
   end

   assign req_ready = count_ff < (QP_W+1)'(Q_DEPTH);
   assign push      = req_valid && req_ready;
   assign q_valid   = count_ff != '0;
   assign q_cmd     = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = wr_ptr_ff + 1'b1;
      if (q_pop) rd_ptr_in = rd_ptr_ff + 1'b1;
      if (push && !q_pop) count_in = count_ff + 1'b1;
      else if (!push && q_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= cls;
   end

endmodule

/* sv/glcm_back.sv */
module glcm_back
   import glcm_pkg::*;
#(
   parameter int GRAY_LEVELS = GRAY_LEVELS_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  cmd_type             q_cmd,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [VALUE_W-1:0]  rsp_read_value,
   output logic [VALUE_W-1:0]  rsp_pair_total,
   output logic                rsp_saturated
);

   localparam int CELLS    = GRAY_LEVELS * GRAY_LEVELS;
   localparam int SUM_BINS = 2 * GRAY_LEVELS - 1;
   localparam int CA_W     = $clog2(CELLS);
   localparam int SUM_W    = $clog2(SUM_BINS);
   localparam int LV_W     = $clog2(GRAY_LEVELS);
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_READ   = 5'b00010,
      ST_UPDATE = 5'b00100,
      ST_CLEAR  = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic                   swap_ff, swap_in;
   logic                   clr_resp_ff, clr_resp_in;
   logic [CA_W-1:0]        clr_idx_ff, clr_idx_in;
   logic [COUNT_BITS-1:0]  val_ff, val_in;
   logic [COUNT_BITS-1:0]  total_ff, total_in;
   logic                   sat_ff, sat_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [VALUE_W-1:0]     rsp_total_ff, rsp_total_in;
   logic                   rsp_sat_ff, rsp_sat_in;

   logic [COUNT_BITS-1:0]  cooc_mem [CELLS];
   logic [COUNT_BITS-1:0]  sum_mem  [SUM_BINS];
   logic [COUNT_BITS-1:0]  diff_mem [GRAY_LEVELS];
   logic [COUNT_BITS-1:0]  x_mem    [GRAY_LEVELS];
   logic [COUNT_BITS-1:0]  y_mem    [GRAY_LEVELS];
   logic [COUNT_BITS-1:0]  cooc_rd_ff, sum_rd_ff, diff_rd_ff, x_rd_ff, y_rd_ff;

   logic [LEVEL_W-1:0]     lvl_a, lvl_b, lvl_d;
   logic [CA_W-1:0]        cell_addr;
   logic [SUM_W-1:0]       sum_addr;
   logic [LV_W-1:0]        diff_addr, x_addr, y_addr;
   logic                   is_add, upd_we, clr_we;
   logic                   clr_sum_ok, clr_lv_ok, clr_last;
   logic [COUNT_BITS-1:0]  cooc_nx, sum_nx, diff_nx, x_nx, y_nx, total_nx;
   logic                   any_sat, out_free;

   // the second entry of a symmetric add swaps the two levels
   assign lvl_a = swap_ff ? cmd_ff.nbr_level : cmd_ff.ref_level;
   assign lvl_b = swap_ff ? cmd_ff.ref_level : cmd_ff.nbr_level;
   assign lvl_d = (lvl_a >= lvl_b) ? (lvl_a - lvl_b) : (lvl_b - lvl_a);
   assign is_add = cmd_ff.op == OP_ADD;

   assign cell_addr = CA_W'(CA_W'(lvl_a) * CA_W'(GRAY_LEVELS)) + CA_W'(lvl_b);
   assign sum_addr  = is_add ? (SUM_W'(lvl_a) + SUM_W'(lvl_b)) : SUM_W'(cmd_ff.bin_index);
   assign diff_addr = is_add ? LV_W'(lvl_d) : LV_W'(cmd_ff.bin_index);
   assign x_addr    = LV_W'(lvl_a);
   assign y_addr    = LV_W'(lvl_b);

   assign upd_we     = (state_ff == ST_UPDATE) && is_add;
   assign clr_we     = state_ff == ST_CLEAR;
   assign clr_sum_ok = 32'(clr_idx_ff) < 32'(SUM_BINS);
   assign clr_lv_ok  = 32'(clr_idx_ff) < 32'(GRAY_LEVELS);
   assign clr_last   = clr_idx_ff == CA_W'(CELLS - 1);

   // saturating increments
   assign cooc_nx  = (cooc_rd_ff == CNT_MAX) ? CNT_MAX : cooc_rd_ff + 1'b1;
   assign sum_nx   = (sum_rd_ff  == CNT_MAX) ? CNT_MAX : sum_rd_ff + 1'b1;
   assign diff_nx  = (diff_rd_ff == CNT_MAX) ? CNT_MAX : diff_rd_ff + 1'b1;
   assign x_nx     = (x_rd_ff    == CNT_MAX) ? CNT_MAX : x_rd_ff + 1'b1;
   assign y_nx     = (y_rd_ff    == CNT_MAX) ? CNT_MAX : y_rd_ff + 1'b1;
   assign total_nx = (total_ff   == CNT_MAX) ? CNT_MAX : total_ff + 1'b1;
   assign any_sat  = (cooc_rd_ff == CNT_MAX) || (sum_rd_ff == CNT_MAX) ||
                     (diff_rd_ff == CNT_MAX) || (x_rd_ff == CNT_MAX) ||
                     (y_rd_ff == CNT_MAX) || (total_ff == CNT_MAX);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      swap_in      = swap_ff;
      clr_resp_in  = clr_resp_ff;
      clr_idx_in   = clr_idx_ff;
      val_in       = val_ff;
      total_in     = total_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_total_in = rsp_total_ff;
      rsp_sat_in   = rsp_sat_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cmd_in  = q_cmd;
               swap_in = 1'b0;
               val_in  = '0;
               case (q_cmd.op)
                  OP_CLEAR: begin
                     clr_idx_in  = '0;
                     clr_resp_in = 1'b1;
                     total_in    = '0;
                     sat_in      = 1'b0;
                     state_in    = ST_CLEAR;
                  end
                  OP_NOP:  state_in = ST_RESP;
                  default: state_in = ST_READ;
               endcase
            end
         end
         ST_READ: state_in = ST_UPDATE;
         ST_UPDATE: begin
            state_in = ST_RESP;
            case (cmd_ff.op)
               OP_ADD: begin
                  total_in = total_nx;
                  if (any_sat) sat_in = 1'b1;
                  if (cmd_ff.sym && !swap_ff) begin
                     swap_in  = 1'b1;
                     state_in = ST_READ;
                  end
               end
               OP_RD_CELL: val_in = cooc_rd_ff;
               OP_RD_SUM:  val_in = sum_rd_ff;
               OP_RD_DIFF: val_in = diff_rd_ff;
               OP_RD_X:    val_in = x_rd_ff;
               OP_RD_Y:    val_in = y_rd_ff;
               default:    val_in = '0;
            endcase
         end
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_last) state_in = clr_resp_ff ? ST_RESP : ST_IDLE;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = VALUE_W'(val_ff);
               rsp_total_in = VALUE_W'(total_ff);
               rsp_sat_in   = sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // reset starts with a sweep that zeroes every store, no transfer follows it
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         swap_ff      <= 1'b0;
         clr_resp_ff  <= 1'b0;
         clr_idx_ff   <= '0;
         total_ff     <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         swap_ff      <= swap_in;
         clr_resp_ff  <= clr_resp_in;
         clr_idx_ff   <= clr_idx_in;
         total_ff     <= total_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      val_ff       <= val_in;
      rsp_value_ff <= rsp_value_in;
      rsp_total_ff <= rsp_total_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   always_ff @(posedge clock) begin
      if (clr_we) cooc_mem[clr_idx_ff] <= '0;
      else if (upd_we) cooc_mem[cell_addr] <= cooc_nx;
      cooc_rd_ff <= cooc_mem[cell_addr];
   end

   always_ff @(posedge clock) begin
      if (clr_we && clr_sum_ok) sum_mem[SUM_W'(clr_idx_ff)] <= '0;
      else if (upd_we) sum_mem[sum_addr] <= sum_nx;
      sum_rd_ff <= sum_mem[sum_addr];
   end

   always_ff @(posedge clock) begin
      if (clr_we && clr_lv_ok) diff_mem[LV_W'(clr_idx_ff)] <= '0;
      else if (upd_we) diff_mem[diff_addr] <= diff_nx;
      diff_rd_ff <= diff_mem[diff_addr];
   end

   always_ff @(posedge clock) begin
      if (clr_we && clr_lv_ok) x_mem[LV_W'(clr_idx_ff)] <= '0;
      else if (upd_we) x_mem[x_addr] <= x_nx;
      x_rd_ff <= x_mem[x_addr];
   end

   always_ff @(posedge clock) begin
      if (clr_we && clr_lv_ok) y_mem[LV_W'(clr_idx_ff)] <= '0;
      else if (upd_we) y_mem[y_addr] <= y_nx;
      y_rd_ff <= y_mem[y_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_pair_total = rsp_total_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule

/* sv/glcm_cooccurrence_accumulator.sv */
// gray-level co-occurrence accumulator
// req channel: one operation per transfer (clear, add pair, or a read of a
// cell, a sum or difference bin, or an x or y marginal). rsp channel: one
// transfer per operation, in order, with the value read (zero for clear,
// add and ignored operations), the pair total and the sticky saturation flag.
// csr port: one register at byte 0, bit 0 = symmetric mode; write only while
// no operation is in flight.
// a two-entry queue sits between the intake and the execution side, and a
// response register sits on the output, so intake keeps going while a
// response waits on rsp_ready.
// each table update is a read-modify-write through the memory read port:
// a read state, then an update state, per counted entry; a symmetric add
// counts two entries and an ignored operation goes straight to the response.
// one operation runs at a time, so the next leaves the queue only once the
// last one has been handed to the response register.
// clear sweeps the co-occurrence table one cell a cycle. after reset the
// same sweep runs before the first operation executes; requests queue up
// meanwhile.
// a stalled rsp_ready holds the response and, once the queue fills, req_ready.
module glcm_cooccurrence_accumulator
   import glcm_pkg::*;
#(
   parameter int GRAY_LEVELS = GRAY_LEVELS_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OP_W-1:0]     req_op,
   input  logic [LEVEL_W-1:0]  req_ref_level,
   input  logic [LEVEL_W-1:0]  req_nbr_level,
   input  logic [BIN_W-1:0]    req_bin_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [VALUE_W-1:0]  rsp_read_value,
   output logic [VALUE_W-1:0]  rsp_pair_total,
   output logic                rsp_saturated,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   logic     sym_ff, sym_in;
   logic     csr_hit;
   logic     q_valid, q_pop;
   cmd_type  q_cmd;

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[2] == CSR_IDX_SYMMETRIC;
   assign sym_in     = (csr_psel && csr_penable && csr_pwrite && csr_hit) ?
                       csr_pwdata[0] : sym_ff;
   assign csr_prdata = csr_hit ? {31'd0, sym_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff <= 1'b0;
      end else begin
         sym_ff <= sym_in;
      end
   end

   glcm_front #(
      .GRAY_LEVELS (GRAY_LEVELS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_ref_level (req_ref_level),
      .req_nbr_level (req_nbr_level),
      .req_bin_index (req_bin_index),
      .sym_mode      (sym_ff),
      .q_valid       (q_valid),
      .q_cmd         (q_cmd),
      .q_pop         (q_pop)
   );

   glcm_back #(
      .GRAY_LEVELS (GRAY_LEVELS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_cmd          (q_cmd),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_pair_total (rsp_pair_total),
      .rsp_saturated  (rsp_saturated)
   );

endmodule
